[rtl/y86_execute_stage_core_assert.svh]
// Assertion macros used by the checker file of the execute stage.
// Each macro expects clk and rst_n in scope at the place of use.
`ifndef Y86_EXECUTE_STAGE_CORE_ASSERT_SVH
`define Y86_EXECUTE_STAGE_CORE_ASSERT_SVH

// Check on every rising edge once reset is released.
`define Y86_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define Y86_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/y86ex_pkg.sv]
// ---------------------------------------------------------------------------
// y86ex_pkg
// Types and codes shared by the execute stage front, queue and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package y86ex_pkg;

    // Instruction codes
    localparam logic [3:0] KIND_CMOV  = 4'h2;
    localparam logic [3:0] KIND_IRMOV = 4'h3;
    localparam logic [3:0] KIND_RMMOV = 4'h4;
    localparam logic [3:0] KIND_MRMOV = 4'h5;
    localparam logic [3:0] KIND_OP    = 4'h6;
    localparam logic [3:0] KIND_JUMP  = 4'h7;
    localparam logic [3:0] KIND_CALL  = 4'h8;
    localparam logic [3:0] KIND_RET   = 4'h9;
    localparam logic [3:0] KIND_PUSH  = 4'hA;
    localparam logic [3:0] KIND_POP   = 4'hB;
    localparam logic [3:0] KIND_IADD  = 4'hC;

    // Function codes of op
    localparam logic [3:0] FUNC_ADD = 4'h0;
    localparam logic [3:0] FUNC_SUB = 4'h1;
    localparam logic [3:0] FUNC_AND = 4'h2;
    localparam logic [3:0] FUNC_XOR = 4'h3;

    // Condition codes of cmov and jump
    localparam logic [3:0] COND_ALWAYS = 4'h0;
    localparam logic [3:0] COND_LE     = 4'h1;
    localparam logic [3:0] COND_L      = 4'h2;
    localparam logic [3:0] COND_E      = 4'h3;
    localparam logic [3:0] COND_NE     = 4'h4;
    localparam logic [3:0] COND_GE     = 4'h5;
    localparam logic [3:0] COND_G      = 4'h6;

    // Internal ALU selections
    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_AND = 2'd2;
    localparam logic [1:0] ALU_XOR = 2'd3;

    localparam logic [63:0] STACK_DEC = 64'hFFFF_FFFF_FFFF_FFF8;
    localparam logic [63:0] STACK_INC = 64'h0000_0000_0000_0008;

    typedef struct packed {
        logic [3:0]         kind;
        logic [3:0]         func_code;
        logic signed [63:0] val_a;
        logic signed [63:0] val_b;
        logic signed [63:0] val_c;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] val_e;
        logic               cond;
        logic               zero_flag;
        logic               sign_flag;
        logic               overflow_flag;
    } out_item_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic [63:0] op_a;
        logic [63:0] op_b;
        logic [1:0]  alu_fn;
        logic        set_cc;
        logic        use_cond;
        logic [3:0]  cond_code;
    } exec_req_t;

endpackage

[rtl/y86ex_front.sv]
// ---------------------------------------------------------------------------
// y86ex_front
// Accepts requests, picks ALU operands, function and flag use, registers them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module y86ex_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  y86ex_pkg::in_item_t  req_data,
    output logic                 cls_valid,
    input  logic                 cls_ready,
    output y86ex_pkg::exec_req_t cls_data
);

    logic                 valid_reg;
    logic                 valid_next;
    y86ex_pkg::exec_req_t data_reg;
    y86ex_pkg::exec_req_t data_next;
    logic                 take;

    assign req_ready = !valid_reg || cls_ready;
    assign take      = req_valid && req_ready;

    always_comb
    begin
        data_next.op_a      = 64'd0;
        data_next.op_b      = 64'd0;
        data_next.alu_fn    = y86ex_pkg::ALU_ADD;
        data_next.set_cc    = 1'b0;
        data_next.use_cond  = 1'b0;
        data_next.cond_code = req_data.func_code;

        unique case (req_data.kind) inside
            y86ex_pkg::KIND_CMOV, y86ex_pkg::KIND_OP:
            begin
                data_next.op_a = req_data.val_a;
            end
            y86ex_pkg::KIND_IRMOV, y86ex_pkg::KIND_RMMOV,
            y86ex_pkg::KIND_MRMOV, y86ex_pkg::KIND_IADD:
            begin
                data_next.op_a = req_data.val_c;
            end
            y86ex_pkg::KIND_CALL, y86ex_pkg::KIND_PUSH:
            begin
                data_next.op_a = y86ex_pkg::STACK_DEC;
            end
            y86ex_pkg::KIND_RET, y86ex_pkg::KIND_POP:
            begin
                data_next.op_a = y86ex_pkg::STACK_INC;
            end
            default:
            begin
                data_next.op_a = 64'd0;
            end
        endcase

        unique case (req_data.kind) inside
            y86ex_pkg::KIND_RMMOV, y86ex_pkg::KIND_MRMOV, y86ex_pkg::KIND_OP,
            y86ex_pkg::KIND_CALL, y86ex_pkg::KIND_RET, y86ex_pkg::KIND_PUSH,
            y86ex_pkg::KIND_POP, y86ex_pkg::KIND_IADD:
            begin
                data_next.op_b = req_data.val_b;
            end
            default:
            begin
                data_next.op_b = 64'd0;
            end
        endcase

        // Only op takes its ALU function from func_code; unknown codes fall back to add
        if (req_data.kind == y86ex_pkg::KIND_OP)
        begin
            unique case (req_data.func_code)
                y86ex_pkg::FUNC_SUB: data_next.alu_fn = y86ex_pkg::ALU_SUB;
                y86ex_pkg::FUNC_AND: data_next.alu_fn = y86ex_pkg::ALU_AND;
                y86ex_pkg::FUNC_XOR: data_next.alu_fn = y86ex_pkg::ALU_XOR;
                default:             data_next.alu_fn = y86ex_pkg::ALU_ADD;
            endcase
        end

        data_next.set_cc   = (req_data.kind == y86ex_pkg::KIND_OP) ||
                             (req_data.kind == y86ex_pkg::KIND_IADD);
        data_next.use_cond = (req_data.kind == y86ex_pkg::KIND_CMOV) ||
                             (req_data.kind == y86ex_pkg::KIND_JUMP);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (cls_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls_data  = data_reg;

endmodule

[rtl/y86ex_queue.sv]
// ---------------------------------------------------------------------------
// y86ex_queue
// Short FIFO of classified requests between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module y86ex_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  y86ex_pkg::exec_req_t wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output y86ex_pkg::exec_req_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    y86ex_pkg::exec_req_t slots [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 push;
    logic                 pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/y86ex_back.sv]
// ---------------------------------------------------------------------------
// y86ex_back
// ALU, condition code registers, condition evaluation and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module y86ex_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 exe_valid,
    output logic                 exe_ready,
    input  y86ex_pkg::exec_req_t exe_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output y86ex_pkg::out_item_t rsp_data
);

    logic                 zero_reg;
    logic                 zero_next;
    logic                 sign_reg;
    logic                 sign_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic                 valid_reg;
    logic                 valid_next;
    y86ex_pkg::out_item_t data_reg;
    y86ex_pkg::out_item_t data_next;
    logic                 take;
    logic [63:0]          sum;
    logic [63:0]          diff;
    logic [63:0]          result;
    logic                 result_ovf;
    logic                 less;
    logic                 cond_val;

    assign exe_ready = !valid_reg || rsp_ready;
    assign take      = exe_valid && exe_ready;

    assign sum  = exe_data.op_b + exe_data.op_a;
    assign diff = exe_data.op_b - exe_data.op_a;

    always_comb
    begin
        case (exe_data.alu_fn)
            y86ex_pkg::ALU_SUB:
            begin
                result     = diff;
                result_ovf = (exe_data.op_a[63] ^ exe_data.op_b[63]) &
                             (exe_data.op_b[63] ^ diff[63]);
            end
            y86ex_pkg::ALU_AND:
            begin
                result     = exe_data.op_a & exe_data.op_b;
                result_ovf = 1'b0;
            end
            y86ex_pkg::ALU_XOR:
            begin
                result     = exe_data.op_a ^ exe_data.op_b;
                result_ovf = 1'b0;
            end
            default:
            begin
                result     = sum;
                result_ovf = ~(exe_data.op_a[63] ^ exe_data.op_b[63]) &
                             (exe_data.op_a[63] ^ sum[63]);
            end
        endcase
    end

    // Condition reads the flags left by earlier requests
    assign less = sign_reg ^ ovf_reg;

    always_comb
    begin
        cond_val = 1'b1;
        if (exe_data.use_cond)
        begin
            unique case (exe_data.cond_code)
                y86ex_pkg::COND_LE: cond_val = less | zero_reg;
                y86ex_pkg::COND_L:  cond_val = less;
                y86ex_pkg::COND_E:  cond_val = zero_reg;
                y86ex_pkg::COND_NE: cond_val = !zero_reg;
                y86ex_pkg::COND_GE: cond_val = !less;
                y86ex_pkg::COND_G:  cond_val = !less && !zero_reg;
                default:            cond_val = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        zero_next = zero_reg;
        sign_next = sign_reg;
        ovf_next  = ovf_reg;
        if (take && exe_data.set_cc)
        begin
            zero_next = (result == 64'd0);
            sign_next = result[63];
            ovf_next  = result_ovf;
        end

        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end

        data_next.val_e         = result;
        data_next.cond          = cond_val;
        data_next.zero_flag     = zero_next;
        data_next.sign_flag     = sign_next;
        data_next.overflow_flag = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg  <= 1'b1;
            sign_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            zero_reg  <= zero_next;
            sign_reg  <= sign_next;
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_data  = data_reg;

endmodule

[rtl/y86_execute_stage_core.sv]
// ---------------------------------------------------------------------------
// y86_execute_stage_core
// Y86-64 execute stage with iaddq: ALU, condition codes and condition check.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_data) takes one instruction per
//   cycle while req_ready is high: instruction code, function code, val_a,
//   val_b and val_c. Response channel (rsp_valid/rsp_ready/rsp_data) returns
//   one response per request, in order: val_e, the condition outcome and the
//   three flags as they stand after that instruction.
//   From request acceptance to response, each request passes through the
//   front register, a queue slot and the back output register.
//   Throughput is one request per cycle while rsp_ready stays high; the
//   flag feedback is a set of one-bit register loops in the back stage, so
//   nothing there limits the rate. Reset clears all valid state and sets
//   the flags to zero=1, sign=0, overflow=0.
//   When the receiver stalls, the output register holds its response, the
//   queue of QUEUE_DEPTH entries fills, and req_ready drops only once the
//   front register and queue are both full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module y86_execute_stage_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  y86ex_pkg::in_item_t  req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output y86ex_pkg::out_item_t rsp_data
);

    logic                 cls_valid;
    logic                 cls_ready;
    y86ex_pkg::exec_req_t cls_data;
    logic                 exe_valid;
    logic                 exe_ready;
    y86ex_pkg::exec_req_t exe_data;

    y86ex_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .cls_valid (cls_valid),
        .cls_ready (cls_ready),
        .cls_data  (cls_data)
    );

    y86ex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cls_valid),
        .wr_ready (cls_ready),
        .wr_data  (cls_data),
        .rd_valid (exe_valid),
        .rd_ready (exe_ready),
        .rd_data  (exe_data)
    );

    y86ex_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .exe_valid (exe_valid),
        .exe_ready (exe_ready),
        .exe_data  (exe_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

[rtl/y86ex_checker.sv]
// ---------------------------------------------------------------------------
// y86ex_checker
// Port-level checks of the execute stage, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "y86_execute_stage_core_assert.svh"

module y86ex_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input y86ex_pkg::out_item_t rsp_data
);

    `Y86_ASSERT_ALWAYS(a_rsp_idle_in_reset, !rst_n |-> !rsp_valid, "response valid during reset")
    `Y86_ASSERT_RUN(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
    `Y86_ASSERT_RUN(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_data), "stalled response changed")
    `Y86_ASSERT_RUN(a_flags_coherent, rsp_valid |-> !(rsp_data.zero_flag && rsp_data.sign_flag), "zero and sign flags both set")

endmodule

bind y86_execute_stage_core y86ex_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
